// ===== sv/rotary_encoder_button_events_defines.svh =====
// ----------------------------------------------------------------------------
// rotary encoder button events - assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_BUTTON_EVENTS_DEFINES_SVH
`define ROTARY_ENCODER_BUTTON_EVENTS_DEFINES_SVH

// same-cycle implication, off during reset
`define REB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("rotary encoder port check failed");

// next-cycle implication, off during reset
`define REB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("rotary encoder port check failed");

// state right after a reset cycle
`define REB_ASSERT_RESET(label, cons) \
    label: assert property (@(posedge i_clk) \
        (!i_rst_n) |=> (cons)) else $error("rotary encoder reset check failed");

`endif

// ===== sv/reb_pkg.sv =====
// ----------------------------------------------------------------------------
// reb_pkg
// types and constants shared by the rotary encoder button event blocks
// ----------------------------------------------------------------------------
`default_nettype none

package reb_pkg;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_RIGHT = 3'd1,
        EV_LEFT  = 3'd2,
        EV_CLICK = 3'd3,
        EV_LONG  = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } t_dir;

    typedef enum logic {
        REG_LONG_PRESS = 1'b0,
        REG_DEBOUNCE   = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] long_press_ms;
        logic [15:0] debounce_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0] quad;
        logic       button;
    } t_sample;

    localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;
    localparam logic [15:0] DEBOUNCE_RESET   = 16'd200;

    localparam int unsigned SEQ_TIMEOUT_MS    = 100;
    localparam int unsigned HOLD_RESET_MS     = 500;
    localparam int unsigned COOLDOWN_MS       = 800;
    localparam int unsigned COOLDOWN_CLEAR_MS = 850;

    localparam logic [1:0] QUAD_REST = 2'b11;

    localparam logic [1:0] CW_SEQ  [4] = '{2'b01, 2'b00, 2'b10, 2'b11};
    localparam logic [1:0] CCW_SEQ [4] = '{2'b10, 2'b00, 2'b01, 2'b11};

    function automatic logic [1:0] seq_code(t_dir dir, logic [1:0] pos);
        seq_code = (dir == DIR_CCW) ? CCW_SEQ[pos] : CW_SEQ[pos];
    endfunction

endpackage

`default_nettype wire

// ===== sv/reb_cfg.sv =====
// ----------------------------------------------------------------------------
// reb_cfg
// apb register file for hold and debounce times
// ----------------------------------------------------------------------------
`default_nettype none

module reb_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    output reb_pkg::t_cfg      o_cfg
);

    reb_pkg::t_cfg r_cfg;
    reb_pkg::t_cfg n_cfg;
    reb_pkg::t_reg_idx w_idx;
    logic w_wr;

    assign pready = 1'b1;
    assign w_idx  = reb_pkg::t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg  = r_cfg;
        prdata = 32'd0;
        case (w_idx)
            reb_pkg::REG_LONG_PRESS: begin
                prdata = {16'd0, r_cfg.long_press_ms};
                if (w_wr) begin
                    n_cfg.long_press_ms = pwdata[15:0];
                end
            end
            reb_pkg::REG_DEBOUNCE: begin
                prdata = {16'd0, r_cfg.debounce_ms};
                if (w_wr) begin
                    n_cfg.debounce_ms = pwdata[15:0];
                end
            end
            default: begin
                prdata = 32'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_ms <= reb_pkg::LONG_PRESS_RESET;
            r_cfg.debounce_ms   <= reb_pkg::DEBOUNCE_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== sv/reb_rot.sv =====
// ----------------------------------------------------------------------------
// reb_rot
// quadrature sequence tracker, reports a full detent step right or left
// ----------------------------------------------------------------------------
`default_nettype none

module reb_rot #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_step,
    input  wire logic [1:0]           i_quad,
    input  wire logic [TIME_BITS-1:0] i_now,
    output reb_pkg::t_event           o_event
);

    logic [1:0]           r_last_quad, n_last_quad;
    logic [1:0]           r_pos, n_pos;
    reb_pkg::t_dir        r_dir, n_dir;
    logic [TIME_BITS-1:0] r_stamp, n_stamp;

    logic [TIME_BITS-1:0] w_seq_el;
    logic [1:0]           w_pos;
    reb_pkg::t_dir        w_dir;

    assign w_seq_el = i_now - r_stamp;

    always_comb begin
        n_last_quad = r_last_quad;
        n_pos       = r_pos;
        n_dir       = r_dir;
        n_stamp     = r_stamp;
        o_event     = reb_pkg::EV_NONE;
        w_pos       = r_pos;
        w_dir       = r_dir;
        if (i_quad != r_last_quad && (i_quad ^ r_last_quad) != 2'b11) begin
            n_last_quad = i_quad;
            // timeout restarts the sequence
            if (r_pos != 2'd0 && w_seq_el > TIME_BITS'(reb_pkg::SEQ_TIMEOUT_MS)) begin
                w_pos = 2'd0;
                w_dir = reb_pkg::DIR_IDLE;
            end
            n_pos = w_pos;
            n_dir = w_dir;
            if (w_pos == 2'd0) begin
                if (i_quad == reb_pkg::CW_SEQ[0]) begin
                    n_dir   = reb_pkg::DIR_CW;
                    n_pos   = 2'd1;
                    n_stamp = i_now;
                end else if (i_quad == reb_pkg::CCW_SEQ[0]) begin
                    n_dir   = reb_pkg::DIR_CCW;
                    n_pos   = 2'd1;
                    n_stamp = i_now;
                end
            end else begin
                case (w_dir)
                    reb_pkg::DIR_CW, reb_pkg::DIR_CCW: begin
                        if (i_quad == reb_pkg::seq_code(w_dir, w_pos)) begin
                            if (w_pos == 2'd3) begin
                                o_event = (w_dir == reb_pkg::DIR_CW) ?
                                          reb_pkg::EV_RIGHT : reb_pkg::EV_LEFT;
                                n_pos   = 2'd0;
                                n_dir   = reb_pkg::DIR_IDLE;
                            end else begin
                                n_pos   = w_pos + 2'd1;
                                n_stamp = i_now;
                            end
                        end else if (i_quad == reb_pkg::QUAD_REST) begin
                            n_pos = 2'd0;
                            n_dir = reb_pkg::DIR_IDLE;
                        end
                    end
                    default: begin
                        if (i_quad == reb_pkg::QUAD_REST) begin
                            n_pos = 2'd0;
                            n_dir = reb_pkg::DIR_IDLE;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_quad <= reb_pkg::QUAD_REST;
            r_pos       <= 2'd0;
            r_dir       <= reb_pkg::DIR_IDLE;
            r_stamp     <= '0;
        end else if (i_step) begin
            r_last_quad <= n_last_quad;
            r_pos       <= n_pos;
            r_dir       <= n_dir;
            r_stamp     <= n_stamp;
        end
    end

endmodule

`default_nettype wire

// ===== sv/reb_btn.sv =====
// ----------------------------------------------------------------------------
// reb_btn
// push button click and long press detection with debounce and cooldown
// ----------------------------------------------------------------------------
`default_nettype none

module reb_btn #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_step,
    input  wire logic                 i_button,
    input  wire logic [TIME_BITS-1:0] i_now,
    input  wire reb_pkg::t_cfg        i_cfg,
    output reb_pkg::t_event           o_event
);

    logic                 r_last_button, n_last_button;
    logic [TIME_BITS-1:0] r_press_start, n_press_start;
    logic                 r_press_valid, n_press_valid;
    logic                 r_long_seen, n_long_seen;
    logic [TIME_BITS-1:0] r_last_action, n_last_action;
    logic [TIME_BITS-1:0] r_cool_start, n_cool_start;
    logic                 r_cool_valid, n_cool_valid;

    logic                 w_press_edge;
    logic                 w_release;
    logic [TIME_BITS-1:0] w_el_press;
    logic [TIME_BITS-1:0] w_el_action;
    logic [TIME_BITS-1:0] w_el_cool;
    logic                 w_long_hit;
    logic                 w_cool_active;
    logic                 w_debounced;

    assign w_press_edge  = r_last_button && !i_button;
    assign w_release     = !r_last_button && i_button;
    assign w_el_press    = i_now - (w_press_edge ? i_now : r_press_start);
    assign w_el_action   = i_now - r_last_action;
    assign w_el_cool     = i_now - r_cool_start;
    assign w_debounced   = w_el_action >= TIME_BITS'(i_cfg.debounce_ms);
    assign w_long_hit    = !i_button && (w_press_edge || !r_long_seen) &&
                           (w_press_edge || r_press_valid) &&
                           (w_el_press >= TIME_BITS'(i_cfg.long_press_ms)) &&
                           w_debounced;
    assign w_cool_active = r_cool_valid && (w_el_cool < TIME_BITS'(reb_pkg::COOLDOWN_MS));

    always_comb begin
        n_last_button = i_button;
        n_press_start = r_press_start;
        n_press_valid = r_press_valid;
        n_long_seen   = r_long_seen;
        n_last_action = r_last_action;
        n_cool_start  = r_cool_start;
        n_cool_valid  = r_cool_valid;
        o_event       = reb_pkg::EV_NONE;
        if (w_press_edge) begin
            n_press_start = i_now;
            n_press_valid = 1'b1;
            n_long_seen   = 1'b0;
        end
        if (w_long_hit) begin
            n_long_seen   = 1'b1;
            n_last_action = i_now;
            n_cool_start  = i_now;
            n_cool_valid  = 1'b1;
            o_event       = reb_pkg::EV_LONG;
        end else if (w_release && w_cool_active) begin
            o_event = reb_pkg::EV_NONE;
        end else if (w_release && !r_long_seen && w_debounced) begin
            n_last_action = i_now;
            o_event       = reb_pkg::EV_CLICK;
        end else begin
            if (w_release && r_long_seen &&
                (!r_cool_valid || w_el_cool > TIME_BITS'(reb_pkg::HOLD_RESET_MS))) begin
                n_long_seen = 1'b0;
            end
            if (r_cool_valid && w_el_cool > TIME_BITS'(reb_pkg::COOLDOWN_CLEAR_MS)) begin
                n_cool_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_button <= 1'b1;
            r_press_start <= '0;
            r_press_valid <= 1'b0;
            r_long_seen   <= 1'b0;
            r_last_action <= '0;
            r_cool_start  <= '0;
            r_cool_valid  <= 1'b0;
        end else if (i_step) begin
            r_last_button <= n_last_button;
            r_press_start <= n_press_start;
            r_press_valid <= n_press_valid;
            r_long_seen   <= n_long_seen;
            r_last_action <= n_last_action;
            r_cool_start  <= n_cool_start;
            r_cool_valid  <= n_cool_valid;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rotary_encoder_button_events.sv =====
// ----------------------------------------------------------------------------
// rotary_encoder_button_events
// quadrature encoder and push button sampler producing one event per sample
//
// input channel: i_valid / o_stall carries one pin sample with its
// millisecond timestamp i_now_ms. output channel: o_valid / i_stall carries
// one event code per sample (none, right, left, click, long press).
// a beat in the input register is decoded against the encoder and button
// state as it moves into the result register, on o_event_code from then on.
// throughput: one beat per cycle unless i_stall holds the result register;
// the single decode stage between the input and result registers updates
// sequence state each step and button state only when no turn is decoded.
// stall: while the result register is held by i_stall a second sample waits
// in the input register and o_stall rises; nothing is dropped.
// reset: synchronous; clears both valid flags, sequence and button state,
// and restores hold time 1000 ms and debounce 200 ms. times wrap modulo
// 2^TIME_BITS. registers: long_press_ms at 0x0, debounce_ms at 0x4.
// ----------------------------------------------------------------------------
`default_nettype none

module rotary_encoder_button_events #(
    parameter int TIME_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_clk_level,
    input  wire logic        i_dt_level,
    input  wire logic        i_button_level,
    input  wire logic [31:0] i_now_ms,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_event_code,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    reb_pkg::t_cfg        w_cfg;
    reb_pkg::t_sample     r_smp;
    logic [TIME_BITS-1:0] r_now;
    logic                 r_in_valid;
    logic                 r_out_valid;
    reb_pkg::t_event      r_ev, n_ev;
    reb_pkg::t_event      w_rot_ev, w_btn_ev;
    logic                 w_out_free;
    logic                 w_step;
    logic                 w_take;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_step     = r_in_valid && w_out_free;
    assign o_stall    = r_in_valid && !w_out_free;
    assign w_take     = i_valid && !o_stall;

    reb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    reb_rot #(.TIME_BITS(TIME_BITS)) u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_quad  (r_smp.quad),
        .i_now   (r_now),
        .o_event (w_rot_ev)
    );

    reb_btn #(.TIME_BITS(TIME_BITS)) u_btn (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step && (w_rot_ev == reb_pkg::EV_NONE)),
        .i_button (r_smp.button),
        .i_now    (r_now),
        .i_cfg    (w_cfg),
        .o_event  (w_btn_ev)
    );

    assign n_ev = (w_rot_ev != reb_pkg::EV_NONE) ? w_rot_ev : w_btn_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_step) begin
                r_in_valid <= 1'b0;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (w_out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_smp.quad   <= {i_clk_level, i_dt_level};
            r_smp.button <= i_button_level;
            r_now        <= TIME_BITS'(i_now_ms);
        end
        if (w_step) begin
            r_ev <= n_ev;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_event_code = r_ev;

endmodule

`default_nettype wire

// ===== sv/reb_chk.sv =====
// ----------------------------------------------------------------------------
// reb_chk
// port level checker for the rotary encoder button event block
// ----------------------------------------------------------------------------
`default_nettype none

`include "rotary_encoder_button_events_defines.svh"

module reb_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [2:0]  o_event_code
);

    // event codes above long press never appear
    `REB_ASSERT_NOW(a_event_range, o_valid, o_event_code <= 3'd4)

    // input only backs up when the result is full and held
    `REB_ASSERT_NOW(a_stall_cause, o_stall, o_valid && i_stall)

    // a held result keeps its code
    `REB_ASSERT_NEXT(a_hold_result, o_valid && i_stall, o_valid && $stable(o_event_code))

    // reset empties both stages
    `REB_ASSERT_RESET(a_reset_empty, !o_valid && !o_stall)

endmodule

bind rotary_encoder_button_events reb_chk u_reb_chk (.*);

`default_nettype wire

// ===== bench/reb_event_checker.sv =====
// ----------------------------------------------------------------------------
// reb_event_checker
// watches the sample and event channels of the rotary encoder button block,
// follows its register writes, predicts one event code per accepted sample
// and compares every accepted event beat with the oldest prediction
// ----------------------------------------------------------------------------
module reb_event_checker
    import reb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic        i_clk_level,
    input  wire logic        i_dt_level,
    input  wire logic        i_button_level,
    input  wire logic [31:0] i_now_ms,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [2:0]  i_event_code,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic        i_pready,
    output int               o_mismatches,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0] hold_ms;
    logic [15:0] gap_ms;

    logic [1:0]  quad_prev;
    logic [1:0]  seq_pos;
    t_dir        seq_dir;
    logic [31:0] seq_time;
    logic        btn_prev;
    logic [31:0] press_time;
    bit          press_seen;
    bit          long_done;
    logic [31:0] action_time;
    logic [31:0] cool_time;
    bit          cool_on;

    t_event      events_due[$];
    int          errs = 0;

    function automatic t_event decode_rotation(input logic [1:0] q, input logic [31:0] now);
        logic [31:0] age;
        logic [1:0]  want;
        if (q == quad_prev || (q ^ quad_prev) == 2'b11) begin
            return EV_NONE;
        end
        quad_prev = q;
        age = now - seq_time;
        if (seq_pos != 2'd0 && age > SEQ_TIMEOUT_MS) begin
            seq_pos = 2'd0;
            seq_dir = DIR_IDLE;
        end
        if (seq_pos == 2'd0) begin
            if (q == CW_SEQ[0]) begin
                seq_dir = DIR_CW;
                seq_pos = 2'd1;
                seq_time = now;
            end else if (q == CCW_SEQ[0]) begin
                seq_dir = DIR_CCW;
                seq_pos = 2'd1;
                seq_time = now;
            end
            return EV_NONE;
        end
        want = (seq_dir == DIR_CCW) ? CCW_SEQ[seq_pos] : CW_SEQ[seq_pos];
        if (seq_dir != DIR_IDLE && q == want) begin
            if (seq_pos == 2'd3) begin
                seq_pos = 2'd0;
                if (seq_dir == DIR_CW) begin
                    seq_dir = DIR_IDLE;
                    return EV_RIGHT;
                end
                seq_dir = DIR_IDLE;
                return EV_LEFT;
            end
            seq_pos = seq_pos + 2'd1;
            seq_time = now;
        end else if (q == QUAD_REST) begin
            seq_pos = 2'd0;
            seq_dir = DIR_IDLE;
        end
        return EV_NONE;
    endfunction

    function automatic t_event decode_button(input logic b, input logic [31:0] now);
        logic [31:0] held;
        logic [31:0] since_act;
        logic [31:0] since_cool;
        if (btn_prev && !b) begin
            press_time = now;
            press_seen = 1'b1;
            long_done = 1'b0;
        end
        held = now - press_time;
        since_act = now - action_time;
        since_cool = now - cool_time;
        if (!b && !long_done && press_seen && held >= hold_ms && since_act >= gap_ms) begin
            long_done = 1'b1;
            action_time = now;
            cool_time = now;
            cool_on = 1'b1;
            btn_prev = b;
            return EV_LONG;
        end
        if (!btn_prev && b) begin
            if (cool_on && since_cool < COOLDOWN_MS) begin
                btn_prev = b;
                return EV_NONE;
            end
            if (!long_done && since_act >= gap_ms) begin
                action_time = now;
                btn_prev = b;
                return EV_CLICK;
            end
            if (long_done && (!cool_on || since_cool > HOLD_RESET_MS)) begin
                long_done = 1'b0;
            end
        end
        if (cool_on && since_cool > COOLDOWN_CLEAR_MS) begin
            cool_on = 1'b0;
        end
        btn_prev = b;
        return EV_NONE;
    endfunction

    task automatic flag(input string msg);
        if (errs < 10) begin
            $display("%0t: %s", $realtime, msg);
        end
        errs++;
    endtask

    always @(posedge i_clk) begin : track
        t_event due;
        t_event ev;
        if (!i_rst_n) begin
            hold_ms = LONG_PRESS_RESET;
            gap_ms = DEBOUNCE_RESET;
            quad_prev = QUAD_REST;
            seq_pos = 2'd0;
            seq_dir = DIR_IDLE;
            seq_time = '0;
            btn_prev = 1'b1;
            press_time = '0;
            press_seen = 1'b0;
            long_done = 1'b0;
            action_time = '0;
            cool_time = '0;
            cool_on = 1'b0;
            events_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[2]))
                    REG_LONG_PRESS: hold_ms = i_pwdata[15:0];
                    REG_DEBOUNCE:   gap_ms = i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (events_due.size() == 0) begin
                    flag($sformatf("event beat %0d with no sample waiting", i_event_code));
                end else begin
                    due = events_due.pop_front();
                    if (i_event_code !== due) begin
                        flag($sformatf("event code expected %0d got %0d", due, i_event_code));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                ev = decode_rotation({i_clk_level, i_dt_level}, i_now_ms);
                if (ev == EV_NONE) begin
                    ev = decode_button(i_button_level, i_now_ms);
                end
                events_due.push_back(ev);
            end
        end
        o_mismatches <= errs;
        o_pending <= events_due.size();
    end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// drives pin samples and register writes into the rotary encoder button
// block: a short directed run, then phases of random rotation, button and
// noise samples under several hold and debounce settings, with random
// stalls on both channels; the checker predicts and compares each event
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import reb_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        i_clk_level;
    logic        i_dt_level;
    logic        i_button_level;
    logic [31:0] i_now_ms;
    logic        i_stall;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic        o_stall;
    logic        o_valid;
    logic [2:0]  o_event_code;
    logic [31:0] prdata;
    logic        pready;

    int          mismatches;
    int          pending;

    logic [31:0] clock_ms;
    logic [1:0]  cur_quad;
    logic        cur_btn;
    logic [15:0] cfg_long;
    logic [15:0] cfg_deb;
    int          items_sent = 0;
    bit          quiet = 1'b0;
    bit          hold_off_req = 1'b0;
    bit          tx_busy = 1'b0;
    int          tx_seg = 0;

    rotary_encoder_button_events u_top (.*);

    reb_event_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_clk_level    (i_clk_level),
        .i_dt_level     (i_dt_level),
        .i_button_level (i_button_level),
        .i_now_ms       (i_now_ms),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_event_code   (o_event_code),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : receiver
        int  burst;
        int  seg;
        bit  busy;
        burst = 0;
        seg = 0;
        busy = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
                i_stall <= 1'b0;
            end else if (quiet) begin
                i_stall <= 1'b0;
            end else begin
                if (seg == 0) begin
                    seg = $urandom_range(20, 120);
                    busy = ($urandom_range(0, 2) != 0);
                end
                seg--;
                if (burst > 0) begin
                    burst--;
                    i_stall <= 1'b1;
                end else if (busy && $urandom_range(0, 3) == 0) begin
                    burst = $urandom_range(0, 4);
                    i_stall <= 1'b1;
                end else begin
                    i_stall <= 1'b0;
                end
            end
        end
    end

    // one sample beat, held until accepted
    task automatic send_sample(input logic [1:0] q, input logic b, input logic [31:0] now);
        if (!quiet) begin
            if (tx_seg <= 0) begin
                tx_seg = $urandom_range(10, 80);
                tx_busy = ($urandom_range(0, 2) != 0);
            end
            tx_seg--;
            if (tx_busy && $urandom_range(0, 3) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_clk_level <= q[1];
        i_dt_level <= q[0];
        i_button_level <= b;
        i_now_ms <= now;
        do @(posedge i_clk); while (o_stall);
        cur_quad = q;
        cur_btn = b;
        clock_ms = now;
        items_sent++;
    endtask

    task automatic advance(input logic [1:0] q, input logic b, input int unsigned dt);
        send_sample(q, b, clock_ms + dt);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] hold, input logic [15:0] deb);
        drain();
        write_reg(REG_LONG_PRESS, hold);
        write_reg(REG_DEBOUNCE, deb);
        cfg_long = hold;
        cfg_deb = deb;
    endtask

    task automatic go_rest();
        if (cur_quad == 2'b00) begin
            advance(CW_SEQ[0], cur_btn, $urandom_range(1, 50));
        end
        if (cur_quad != QUAD_REST) begin
            advance(QUAD_REST, cur_btn, $urandom_range(1, 50));
        end
    endtask

    task automatic turn(input bit ccw, input int unsigned max_dt);
        logic b;
        go_rest();
        for (int i = 0; i < 4; i++) begin
            b = cur_btn;
            if ($urandom_range(0, 7) == 0) begin
                b = ~b;
            end
            advance(ccw ? CCW_SEQ[i] : CW_SEQ[i], b, $urandom_range(1, max_dt));
        end
    endtask

    task automatic press_hold();
        int unsigned total;
        int unsigned n;
        total = $urandom_range(0, 2 * int'(cfg_long) + 50);
        n = $urandom_range(1, 5);
        advance(cur_quad, 1'b0, $urandom_range(0, 300));
        repeat (n) advance(cur_quad, 1'b0, total / n);
        advance(cur_quad, 1'b1, $urandom_range(0, 1200));
        if ($urandom_range(0, 1) != 0) begin
            advance(cur_quad, 1'b1, $urandom_range(0, 900));
        end
    endtask

    task automatic click_burst();
        int unsigned span;
        span = 2 * int'(cfg_deb) + 20;
        repeat ($urandom_range(2, 6)) begin
            advance(cur_quad, 1'b0, $urandom_range(0, span));
            advance(cur_quad, 1'b1, $urandom_range(0, span));
        end
    endtask

    task automatic broken();
        bit          ccw;
        int unsigned k;
        ccw = $urandom_range(0, 1);
        case ($urandom_range(0, 3))
            0: begin
                go_rest();
                k = $urandom_range(1, 3);
                for (int i = 0; i < k; i++) begin
                    advance(ccw ? CCW_SEQ[i] : CW_SEQ[i], cur_btn, $urandom_range(1, 60));
                end
                advance(2'($urandom_range(0, 3)), cur_btn, $urandom_range(1, 60));
            end
            1: begin
                go_rest();
                for (int i = 0; i < 4; i++) begin
                    advance(ccw ? CCW_SEQ[i] : CW_SEQ[i], cur_btn, $urandom_range(80, 160));
                end
            end
            2: begin
                advance(~cur_quad, cur_btn, $urandom_range(0, 60));
                advance(~cur_quad, cur_btn, $urandom_range(0, 60));
            end
            default: begin
                repeat ($urandom_range(1, 3)) advance(cur_quad, cur_btn, $urandom_range(0, 300));
            end
        endcase
    endtask

    task automatic noise();
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 4) == 0) begin
                send_sample(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom);
            end else begin
                advance(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                        $urandom_range(0, 400));
            end
        end
    endtask

    task automatic run_items(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2: turn($urandom_range(0, 1), ($urandom_range(0, 4) == 0) ? 130 : 60);
                3, 4:    press_hold();
                5:       click_burst();
                6, 7:    broken();
                default: noise();
            endcase
        end
    endtask

    initial begin : stimulus
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_clk_level <= 1'b1;
        i_dt_level <= 1'b1;
        i_button_level <= 1'b1;
        i_now_ms <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        clock_ms = 32'hFFFF_F000;
        cur_quad = QUAD_REST;
        cur_btn = 1'b1;
        cfg_long = LONG_PRESS_RESET;
        cfg_deb = DEBOUNCE_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full turns each way, then ignored changes
        send_sample(2'b11, 1'b1, 32'd0);
        send_sample(2'b01, 1'b1, 32'd10);
        send_sample(2'b00, 1'b1, 32'd20);
        send_sample(2'b10, 1'b1, 32'd30);
        send_sample(2'b11, 1'b1, 32'd40);
        send_sample(2'b10, 1'b1, 32'd50);
        send_sample(2'b00, 1'b1, 32'd60);
        send_sample(2'b01, 1'b1, 32'd70);
        send_sample(2'b11, 1'b1, 32'd80);
        send_sample(2'b00, 1'b1, 32'd90);
        // sequence timeout, then stray returns to rest
        send_sample(2'b01, 1'b1, 32'd100);
        send_sample(2'b00, 1'b1, 32'd300);
        send_sample(2'b10, 1'b1, 32'd310);
        send_sample(2'b11, 1'b1, 32'd320);
        send_sample(2'b01, 1'b1, 32'd330);
        send_sample(2'b11, 1'b1, 32'd340);
        // long press, release in cooldown, click, debounced click
        send_sample(2'b11, 1'b0, 32'd400);
        send_sample(2'b11, 1'b0, 32'd1400);
        send_sample(2'b11, 1'b1, 32'd1500);
        send_sample(2'b11, 1'b0, 32'd2500);
        send_sample(2'b11, 1'b1, 32'd2600);
        send_sample(2'b11, 1'b0, 32'd2650);
        send_sample(2'b11, 1'b1, 32'd2700);
        // timestamp extremes and wrap
        send_sample(2'b11, 1'b1, 32'hFFFF_FFFF);
        send_sample(2'b01, 1'b1, 32'd5);
        send_sample(2'b00, 1'b1, 32'd16);

        run_items(200);
        configure(16'd0, 16'd0);
        run_items(200);
        configure(16'hFFFF, 16'hFFFF);
        run_items(200);
        configure(16'($urandom_range(0, 400)), 16'($urandom_range(0, 150)));
        hold_off_req = 1'b1;
        run_items(200);
        configure(16'd0, 16'hFFFF);
        run_items(100);
        drain();
        run_items(100);
        configure(16'hFFFF, 16'd0);
        run_items(200);
        configure(16'($urandom_range(0, 400)), 16'($urandom_range(0, 150)));
        run_items(200);
        configure(16'($urandom_range(0, 400)), 16'($urandom_range(0, 150)));
        quiet = 1'b1;
        run_items(200);

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/reb_pkg.sv
sv/reb_cfg.sv
sv/reb_rot.sv
sv/reb_btn.sv
sv/rotary_encoder_button_events.sv
sv/reb_chk.sv
bench/reb_event_checker.sv
bench/tb.sv
